### src/vertex_rotate_project_assert.svh
// Assertion macros for the vertex rotate and project block.
// Used by the top level; expects a clock named i_clk and a reset named i_rst_n.
`ifndef VERTEX_ROTATE_PROJECT_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_ASSERT_SVH

// same-cycle implication
`define VRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrp assertion failed");

// next-cycle implication
`define VRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrp assertion failed");

`endif

### src/vrp_pkg.sv
// Shared types and constants for the vertex rotate and project block.
// No dependencies.
`default_nettype none
package vrp_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_FRAC      = 14;
    localparam int POS_FRAC        = 12;
    localparam int PIX_WIDTH       = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH   = 3;

    localparam logic signed [15:0] COS_RESET   = 16'sd16364;
    localparam logic signed [15:0] SIN_RESET   = 16'sd819;
    localparam logic [14:0]        EYE_RESET   = 15'd8192;
    localparam logic [9:0]         SCALE_RESET = 10'd100;
    localparam logic [11:0]        OFFX_RESET  = 12'd750;
    localparam logic [11:0]        OFFY_RESET  = 12'd450;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_COS   = 3'd0,
        CFG_SIN   = 3'd1,
        CFG_EYE   = 3'd2,
        CFG_SCALE = 3'd3,
        CFG_OFFX  = 3'd4,
        CFG_OFFY  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage
`default_nettype wire

### src/vrp_rot.sv
// One rotation step in two register stages: products, then floor and saturate.
// Depends on vrp_pkg.
`default_nettype none
module vrp_rot #(
    parameter int CW = vrp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  vrp_pkg::t_pipe_ctl         i_ctl,
    input  wire logic signed [15:0]    i_c,
    input  wire logic signed [15:0]    i_s,
    input  wire logic signed [CW-1:0]  i_a,
    input  wire logic signed [CW-1:0]  i_b,
    input  wire logic signed [CW-1:0]  i_pass,
    output logic                       o_valid,
    output logic signed [CW-1:0]       o_p,
    output logic signed [CW-1:0]       o_q,
    output logic signed [CW-1:0]       o_pass
);
    import vrp_pkg::*;

    localparam int MW  = CW + 16;
    localparam int SW  = CW + 17;
    localparam int SHW = SW - ANGLE_FRAC;

    logic signed [MW-1:0] r_ca, r_sb, r_cb, r_sa;
    logic signed [CW-1:0] r_pass1;
    logic                 r_v1;

    logic signed [SW-1:0] n_sum_p, n_sum_q;
    logic [SHW-1:0]       n_sh_p, n_sh_q;
    logic [CW-1:0]        n_p, n_q;

    function automatic logic [CW-1:0] sat_coord(input logic [SHW-1:0] v);
        logic [CW-1:0] r;
        r = v[CW-1:0];
        if (!v[SHW-1] && (|v[SHW-2:CW-1])) begin
            r = {1'b0, {(CW-1){1'b1}}};
        end else if (v[SHW-1] && !(&v[SHW-2:CW-1])) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1    <= i_ctl.valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ca    <= i_c * i_a;
            r_sb    <= i_s * i_b;
            r_cb    <= i_c * i_b;
            r_sa    <= i_s * i_a;
            r_pass1 <= i_pass;
            o_p     <= n_p;
            o_q     <= n_q;
            o_pass  <= r_pass1;
        end
    end

    always_comb begin
        n_sum_p = SW'(r_ca) + SW'(r_sb);
        n_sum_q = SW'(r_cb) - SW'(r_sa);
        n_sh_p  = n_sum_p[SW-1:ANGLE_FRAC];
        n_sh_q  = n_sum_q[SW-1:ANGLE_FRAC];
        n_p     = sat_coord(n_sh_p);
        n_q     = sat_coord(n_sh_q);
    end

endmodule
`default_nettype wire

### src/vrp_div.sv
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared divisor, with a sideband carried alongside. Depends on vrp_pkg.
`default_nettype none
module vrp_div #(
    parameter int NW = 28,
    parameter int DW = 16,
    parameter int SW = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  vrp_pkg::t_pipe_ctl         i_ctl,
    input  wire logic [1:0][NW-1:0]    i_num,
    input  wire logic [DW-1:0]         i_den,
    input  wire logic [SW-1:0]         i_side,
    output logic                       o_valid,
    output logic [1:0][NW-1:0]         o_quo,
    output logic [SW-1:0]              o_side
);
    import vrp_pkg::*;

    logic [1:0][NW-1:0] r_nq   [NW];
    logic [1:0][DW-1:0] r_rem  [NW];
    logic [DW-1:0]      r_den  [NW];
    logic [SW-1:0]      r_side [NW];
    logic               r_v    [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [1:0][NW-1:0] w_nq;
        logic [1:0][DW-1:0] w_rem;
        logic [DW-1:0]      w_den;
        logic [SW-1:0]      w_side;
        logic               w_v;
        logic [1:0][NW-1:0] n_nq;
        logic [1:0][DW-1:0] n_rem;
        logic [DW:0]        t0, t1;

        if (k == 0) begin : g_first
            assign w_nq   = i_num;
            assign w_rem  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_v    = i_ctl.valid;
        end else begin : g_next
            assign w_nq   = r_nq[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
            assign w_v    = r_v[k-1];
        end

        always_comb begin
            t0 = {w_rem[0], w_nq[0][NW-1]};
            t1 = {w_rem[1], w_nq[1][NW-1]};
            if (t0 >= {1'b0, w_den}) begin
                n_rem[0] = DW'(t0 - {1'b0, w_den});
                n_nq[0]  = {w_nq[0][NW-2:0], 1'b1};
            end else begin
                n_rem[0] = t0[DW-1:0];
                n_nq[0]  = {w_nq[0][NW-2:0], 1'b0};
            end
            if (t1 >= {1'b0, w_den}) begin
                n_rem[1] = DW'(t1 - {1'b0, w_den});
                n_nq[1]  = {w_nq[1][NW-2:0], 1'b1};
            end else begin
                n_rem[1] = t1[DW-1:0];
                n_nq[1]  = {w_nq[1][NW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_nq[k]   <= n_nq;
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_side  = r_side[NW-1];

endmodule
`default_nettype wire

### src/vertex_rotate_project.sv
// Pipeline order: rotation about y, x and z, divisor setup, the divider, then the scale,
// offset and truncate registers and the output register. Throughput: one vertex per cycle
// while o_stall is low; the bit-serial divider pipeline sets the depth.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Depends on vrp_pkg, vrp_rot, vrp_div and vertex_rotate_project_assert.svh.
`default_nettype none
module vertex_rotate_project #(
    parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [vrp_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [vrp_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]         i_vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0]         i_vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0]         i_vertex_z,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [COORD_WIDTH-1:0]              o_rotated_x,
    output logic signed [COORD_WIDTH-1:0]              o_rotated_y,
    output logic signed [COORD_WIDTH-1:0]              o_rotated_z,
    output logic signed [vrp_pkg::PIX_WIDTH-1:0]       o_screen_x,
    output logic signed [vrp_pkg::PIX_WIDTH-1:0]       o_screen_y,
    output logic                                       o_behind_eye
);
    import vrp_pkg::*;
    `include "vertex_rotate_project_assert.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = (CW > 16) ? CW : 16;
    localparam int DSW = DW + 1;
    localparam int NW  = CW + POS_FRAC;
    localparam int QW  = NW + 1;
    localparam int PW  = QW + 11;
    localparam int VW  = PW + 1;
    localparam int TW  = VW - POS_FRAC;
    localparam int SBW = 3 * CW + 3;
    localparam int RW  = 3 * CW + 2 * PIX_WIDTH + 1;

    logic signed [15:0] r_cos, r_sin;
    logic [14:0]        r_eye;
    logic [9:0]         r_scale;
    logic [11:0]        r_offx, r_offy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= COS_RESET;
            r_sin   <= SIN_RESET;
            r_eye   <= EYE_RESET;
            r_scale <= SCALE_RESET;
            r_offx  <= OFFX_RESET;
            r_offy  <= OFFY_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COS:   r_cos   <= i_cfg_data;
                CFG_SIN:   r_sin   <= i_cfg_data;
                CFG_EYE:   r_eye   <= i_cfg_data[14:0];
                CFG_SCALE: r_scale <= i_cfg_data[9:0];
                CFG_OFFX:  r_offx  <= i_cfg_data[11:0];
                CFG_OFFY:  r_offy  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic      r_skid_valid;
    logic      pipe_en;
    t_pipe_ctl ctl_in, ctl_y, ctl_x, ctl_z, ctl_d;

    assign pipe_en = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign ctl_in  = '{en: pipe_en, valid: i_valid};

    logic                 v_y, v_x, v_z;
    logic signed [CW-1:0] y_p, y_q, y_pass, x_p, x_q, x_pass, z_p, z_q, z_pass;

    assign ctl_y = '{en: pipe_en, valid: v_y};
    assign ctl_x = '{en: pipe_en, valid: v_x};

    vrp_rot #(.CW(CW)) u_rot_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_in), .i_c(r_cos), .i_s(r_sin),
        .i_a(i_vertex_x), .i_b(i_vertex_z), .i_pass(i_vertex_y),
        .o_valid(v_y), .o_p(y_p), .o_q(y_q), .o_pass(y_pass)
    );

    vrp_rot #(.CW(CW)) u_rot_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_y), .i_c(r_cos), .i_s(r_sin),
        .i_a(y_q), .i_b(y_pass), .i_pass(y_p),
        .o_valid(v_x), .o_p(x_p), .o_q(x_q), .o_pass(x_pass)
    );

    vrp_rot #(.CW(CW)) u_rot_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_x), .i_c(r_cos), .i_s(r_sin),
        .i_a(x_q), .i_b(x_pass), .i_pass(x_p),
        .o_valid(v_z), .o_p(z_p), .o_q(z_q), .o_pass(z_pass)
    );

    // z_q is rotated x, z_p is rotated y, z_pass is rotated z
    logic signed [DSW-1:0] n_d;
    logic                  n_behind;
    logic [CW-1:0]         n_mag_x, n_mag_y;
    logic [1:0][NW-1:0]    r_d_num;
    logic [DW-1:0]         r_d_den;
    logic [SBW-1:0]        r_d_side;
    logic                  r_d_v;

    always_comb begin
        n_d      = DSW'($signed({1'b0, r_eye})) - DSW'(z_pass);
        n_behind = n_d[DSW-1] || (n_d == '0);
        n_mag_x  = z_q[CW-1] ? CW'(-z_q) : z_q;
        n_mag_y  = z_p[CW-1] ? CW'(-z_p) : z_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (pipe_en) begin
            r_d_v <= v_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_d_num[0] <= {n_mag_x, {POS_FRAC{1'b0}}};
            r_d_num[1] <= {n_mag_y, {POS_FRAC{1'b0}}};
            r_d_den    <= n_behind ? DW'(1) : n_d[DW-1:0];
            r_d_side   <= {n_behind, z_p[CW-1], z_q[CW-1], z_pass, z_p, z_q};
        end
    end

    assign ctl_d = '{en: pipe_en, valid: r_d_v};

    logic               v_q;
    logic [1:0][NW-1:0] quo;
    logic [SBW-1:0]     q_side;

    vrp_div #(.NW(NW), .DW(DW), .SW(SBW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_d), .i_num(r_d_num),
        .i_den(r_d_den), .i_side(r_d_side),
        .o_valid(v_q), .o_quo(quo), .o_side(q_side)
    );

    logic signed [PW-1:0]        r_m_prod [2];
    logic signed [VW-1:0]        r_a_sum  [2];
    logic [PIX_WIDTH-1:0]        r_t_pix  [2];
    logic [SBW-1:0]              r_m_side, r_a_side, r_t_side;
    logic                        r_m_v, r_a_v, r_t_v;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [QW-1:0] n_q;
        logic [11:0]          w_off;
        logic signed [VW-1:0] n_adj;
        logic [TW-1:0]        n_tr;
        logic [PIX_WIDTH-1:0] n_pix;

        assign w_off = (l == 0) ? r_offx : r_offy;

        always_comb begin
            n_q   = q_side[3*CW+l] ? -QW'(quo[l]) : QW'(quo[l]);
            n_adj = r_a_sum[l] + (r_a_sum[l][VW-1] ? VW'(4095) : VW'(0));
            n_tr  = n_adj[VW-1:POS_FRAC];
            n_pix = n_tr[PIX_WIDTH-1:0];
            if (!n_tr[TW-1] && (|n_tr[TW-2:PIX_WIDTH-1])) begin
                n_pix = {1'b0, {(PIX_WIDTH-1){1'b1}}};
            end else if (n_tr[TW-1] && !(&n_tr[TW-2:PIX_WIDTH-1])) begin
                n_pix = {1'b1, {(PIX_WIDTH-1){1'b0}}};
            end
            if (r_a_side[3*CW+2]) begin
                n_pix = '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_m_prod[l] <= n_q * $signed({1'b0, r_scale});
                r_a_sum[l]  <= VW'(r_m_prod[l]) + VW'($signed({1'b0, w_off, 12'b0}));
                r_t_pix[l]  <= n_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_a_v <= 1'b0;
            r_t_v <= 1'b0;
        end else if (pipe_en) begin
            r_m_v <= v_q;
            r_a_v <= r_m_v;
            r_t_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m_side <= q_side;
            r_a_side <= r_m_side;
            r_t_side <= r_a_side;
        end
    end

    // output register with a one-beat skid
    logic [RW-1:0] n_res, r_out, r_skid;
    logic          r_out_valid;

    assign n_res = {r_t_side[3*CW+2], r_t_pix[1], r_t_pix[0], r_t_side[3*CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_t_v;
            end
        end else if (r_t_v && pipe_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (r_t_v && pipe_en) begin
            r_skid <= n_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_rotated_x  = r_out[CW-1:0];
    assign o_rotated_y  = r_out[2*CW-1:CW];
    assign o_rotated_z  = r_out[3*CW-1:2*CW];
    assign o_screen_x   = r_out[3*CW+PIX_WIDTH-1:3*CW];
    assign o_screen_y   = r_out[3*CW+2*PIX_WIDTH-1:3*CW+PIX_WIDTH];
    assign o_behind_eye = r_out[RW-1];

    `VRP_ASSERT_IMP(a_skid_needs_out, r_skid_valid, r_out_valid)
    `VRP_ASSERT_NXT(a_skid_drains, r_skid_valid && !i_stall, !r_skid_valid)
    `VRP_ASSERT_IMP(a_behind_zero, o_valid && o_behind_eye, (o_screen_x == '0) && (o_screen_y == '0))

endmodule
`default_nettype wire
